[design/circular_log_sequence_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the circular log sequence tracker
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LOG_SEQUENCE_TRACKER_MACROS_SVH
`define CIRCULAR_LOG_SEQUENCE_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CLST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clst check failed");

// next-cycle implication
`define CLST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clst check failed");

`else

`define CLST_ASSERT_IMPL(label, clk, rst, ante, cons)

`define CLST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/clst_pkg.sv]
// ----------------------------------------------------------------------------
// clst_pkg
// Shared types and constants of the circular log sequence tracker.
// ----------------------------------------------------------------------------
package clst_pkg;

   localparam int SEQ_W  = 16;
   localparam int SLOT_W = 8;
   localparam int FUNC_W = 3;
   localparam int IDX_W  = 7;
   localparam int CSR_W  = 8;

   localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = 16'hFFFF;
   localparam logic [SEQ_W-1:0] SEQ_ONE      = 16'h0001;
   localparam logic [CSR_W-1:0] CSR_RESET    = 8'd128;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND     = 3'd0,
      FUNC_BR_NEXT    = 3'd1,
      FUNC_BR_PREV    = 3'd2,
      FUNC_FIND       = 3'd3,
      FUNC_WIPE       = 3'd4,
      FUNC_LOAD_SLOT  = 3'd5,
      FUNC_LOAD_EPOCH = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOC_RD,
      ST_LOC_DATA,
      ST_SCAN,
      ST_APPEND_WR,
      ST_BR_A_RD,
      ST_BR_A_DATA,
      ST_BR_B_RD,
      ST_BR_B_DATA,
      ST_WIPE,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  current_slot;
      logic [SEQ_W-1:0]   current_seq;
      logic [2*SEQ_W-1:0] log_number;
      logic               moved;
      logic [SLOT_W-1:0]  latest_slot;
      logic [SEQ_W-1:0]   stored_epoch;
      logic               epoch_bumped;
   } rsp_type;

endpackage

[design/clst_mem.sv]
// ----------------------------------------------------------------------------
// clst_mem
// Slot sequence store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clst_mem import clst_pkg::*; #(
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [SEQ_W-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [SEQ_W-1:0] rdata
);

   logic [SEQ_W-1:0] mem_ff [DEPTH];
   logic [SEQ_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/clst_newer.sv]
// ----------------------------------------------------------------------------
// clst_newer
// Serial-number compare: a is newer than b when a - b is nonzero and below
// half the sequence space.
// ----------------------------------------------------------------------------
module clst_newer import clst_pkg::*; (
   input  logic [SEQ_W-1:0] a,
   input  logic [SEQ_W-1:0] b,
   output logic             newer
);

   logic [SEQ_W-1:0] diff;

   assign diff  = a - b;
   assign newer = (diff != '0) && !diff[SEQ_W-1];

endmodule

[design/clst_seq.sv]
// ----------------------------------------------------------------------------
// clst_seq
// Sequencer and state of the tracker: walks the slot store through its read
// port and reuses one serial-number compare for scans and browse steps.
// ----------------------------------------------------------------------------
`include "circular_log_sequence_tracker_macros.svh"

module clst_seq import clst_pkg::*; #(
   parameter int MAX_SLOTS = 128,
   localparam int AW = $clog2(MAX_SLOTS),
   localparam int CW = $clog2(MAX_SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CSR_W-1:0]  slots_in_use,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [IDX_W-1:0]  req_slot_index,
   input  logic [SEQ_W-1:0]  req_seq_value,
   input  logic              rsp_free,
   output logic              done,
   output rsp_type           result
);

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SEQ_W-1:0] val_ff, val_in;

   logic             sel_valid_ff, sel_valid_in;
   logic [AW-1:0]    sel_idx_ff, sel_idx_in;
   logic             nw_valid_ff, nw_valid_in;
   logic [AW-1:0]    nw_idx_ff, nw_idx_in;
   logic [SEQ_W-1:0] wrap_ff, wrap_in;
   logic [SEQ_W-1:0] view_ff, view_in;
   logic [SEQ_W-1:0] cur_ff, cur_in;
   logic             moved_ff, moved_in;
   logic             bumped_ff, bumped_in;

   logic [CW-1:0]    scan_i_ff, scan_i_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [AW-1:0]    chk_idx_ff, chk_idx_in;
   logic             best_valid_ff, best_valid_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic [SEQ_W-1:0] best_seq_ff, best_seq_in;
   logic [AW-1:0]    tgt_ff, tgt_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [SEQ_W-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [SEQ_W-1:0] mem_rdata;

   logic [SEQ_W-1:0] cmp_a, cmp_b;
   logic             cmp_newer;

   logic [31:0]      csr_wide;
   logic [CW-1:0]    n_val;
   logic [CW-1:0]    sel_plus;
   logic [AW-1:0]    step_next_idx;
   logic [AW-1:0]    step_prev_idx;
   logic             clr_last;
   logic             scan_issue;
   logic             scan_done;
   logic             idx_ok;
   logic             cur_wraps;
   logic [SEQ_W-1:0] append_seq;
   logic [AW-1:0]    append_idx;

   clst_mem #(.DEPTH(MAX_SLOTS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   clst_newer u_newer (
      .a     (cmp_a),
      .b     (cmp_b),
      .newer (cmp_newer)
   );

   // effective ring size, limited to 1..MAX_SLOTS
   assign csr_wide = 32'(slots_in_use);
   assign n_val = (slots_in_use == '0) ? CW'(1) :
                  (csr_wide > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(csr_wide);

   assign sel_plus      = CW'(sel_idx_ff) + CW'(1);
   assign step_next_idx = (sel_plus >= n_val) ? '0 : AW'(sel_plus);
   assign step_prev_idx = (sel_idx_ff == '0 || CW'(sel_idx_ff) > n_val) ?
                          AW'(n_val - CW'(1)) : sel_idx_ff - AW'(1);

   assign clr_last   = (clr_ff == AW'(MAX_SLOTS - 1));
   assign scan_issue = (scan_i_ff < n_val);
   assign scan_done  = !scan_issue && !chk_valid_ff;
   assign idx_ok     = (32'(idx_ff) < 32'(MAX_SLOTS));

   assign cur_wraps  = (cur_ff == SEQ_ALL_ONES);
   assign append_seq = cur_wraps ? SEQ_ONE : cur_ff + SEQ_ONE;
   assign append_idx = sel_valid_ff ? step_next_idx : '0;

   // browse compares (target vs. origin); otherwise the scan candidate vs. best
   always_comb begin
      if (state_ff == ST_BR_B_DATA && func_ff == FUNC_BR_PREV) begin
         cmp_a = cur_ff;
         cmp_b = mem_rdata;
      end else if (state_ff == ST_BR_B_DATA) begin
         cmp_a = mem_rdata;
         cmp_b = cur_ff;
      end else begin
         cmp_a = mem_rdata;
         cmp_b = best_seq_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (func_type'(req_func))
                  FUNC_APPEND, FUNC_FIND: begin
                     state_in = nw_valid_ff ? ST_LOC_RD : ST_SCAN;
                  end
                  FUNC_BR_NEXT, FUNC_BR_PREV: begin
                     state_in = sel_valid_ff ? ST_BR_B_RD : ST_BR_A_RD;
                  end
                  FUNC_WIPE:                       state_in = ST_WIPE;
                  FUNC_LOAD_SLOT, FUNC_LOAD_EPOCH: state_in = ST_LOAD;
                  default:                         state_in = ST_RESP;
               endcase
            end
         end
         ST_LOC_RD:   state_in = ST_LOC_DATA;
         ST_LOC_DATA: state_in = (func_ff == FUNC_APPEND) ? ST_APPEND_WR : ST_RESP;
         ST_SCAN: begin
            if (scan_done) state_in = (func_ff == FUNC_APPEND) ? ST_APPEND_WR : ST_RESP;
         end
         ST_APPEND_WR: state_in = ST_RESP;
         ST_BR_A_RD:   state_in = ST_BR_A_DATA;
         ST_BR_A_DATA: state_in = (func_ff == FUNC_BR_NEXT) ? ST_RESP : ST_BR_B_RD;
         ST_BR_B_RD:   state_in = ST_BR_B_DATA;
         ST_BR_B_DATA: state_in = ST_RESP;
         ST_WIPE: begin
            if (clr_last) state_in = ST_RESP;
         end
         ST_LOAD: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      func_in       = func_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      sel_valid_in  = sel_valid_ff;
      sel_idx_in    = sel_idx_ff;
      nw_valid_in   = nw_valid_ff;
      nw_idx_in     = nw_idx_ff;
      wrap_in       = wrap_ff;
      view_in       = view_ff;
      cur_in        = cur_ff;
      moved_in      = moved_ff;
      bumped_in     = bumped_ff;
      scan_i_in     = scan_i_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_seq_in   = best_seq_ff;
      tgt_in        = tgt_ff;
      clr_in        = clr_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = func_type'(req_func);
               idx_in        = req_slot_index;
               val_in        = req_seq_value;
               moved_in      = 1'b0;
               bumped_in     = 1'b0;
               scan_i_in     = '0;
               chk_valid_in  = 1'b0;
               best_valid_in = 1'b0;
               best_seq_in   = '0;
               clr_in        = '0;
            end
         end
         ST_LOC_RD: begin
            mem_raddr = nw_idx_ff;
         end
         ST_LOC_DATA: begin
            sel_valid_in = 1'b1;
            sel_idx_in   = nw_idx_ff;
            cur_in       = mem_rdata;
            view_in      = wrap_ff;
         end
         ST_SCAN: begin
            // one read issued per cycle, checked in the cycle after
            if (scan_issue) begin
               mem_raddr = AW'(scan_i_ff);
               scan_i_in = scan_i_ff + CW'(1);
            end
            chk_valid_in = scan_issue;
            chk_idx_in   = AW'(scan_i_ff);
            if (chk_valid_ff && mem_rdata != '0 && (!best_valid_ff || cmp_newer)) begin
               best_valid_in = 1'b1;
               best_idx_in   = chk_idx_ff;
               best_seq_in   = mem_rdata;
            end
            if (scan_done) begin
               sel_valid_in = best_valid_ff;
               sel_idx_in   = best_idx_ff;
               nw_valid_in  = best_valid_ff;
               nw_idx_in    = best_idx_ff;
               cur_in       = best_seq_ff;
               view_in      = wrap_ff;
            end
         end
         ST_APPEND_WR: begin
            if (cur_wraps) begin
               wrap_in   = wrap_ff + SEQ_ONE;
               view_in   = wrap_ff + SEQ_ONE;
               bumped_in = 1'b1;
            end
            mem_we       = 1'b1;
            mem_waddr    = append_idx;
            mem_wdata    = append_seq;
            sel_valid_in = 1'b1;
            sel_idx_in   = append_idx;
            nw_valid_in  = 1'b1;
            nw_idx_in    = append_idx;
            cur_in       = append_seq;
         end
         ST_BR_A_RD: begin
            mem_raddr = '0;
         end
         ST_BR_A_DATA: begin
            // nothing selected: origin is slot 0
            sel_valid_in = 1'b1;
            sel_idx_in   = '0;
            cur_in       = mem_rdata;
            moved_in     = (func_ff == FUNC_BR_NEXT);
         end
         ST_BR_B_RD: begin
            tgt_in    = (func_ff == FUNC_BR_NEXT) ? step_next_idx : step_prev_idx;
            mem_raddr = tgt_in;
         end
         ST_BR_B_DATA: begin
            if (mem_rdata != '0 && cmp_newer) begin
               moved_in   = 1'b1;
               sel_idx_in = tgt_ff;
               cur_in     = mem_rdata;
               if (func_ff == FUNC_BR_NEXT && cur_ff == SEQ_ALL_ONES && mem_rdata == SEQ_ONE)
               begin
                  view_in = view_ff + SEQ_ONE;
               end
               if (func_ff == FUNC_BR_PREV && cur_ff == SEQ_ONE && mem_rdata == SEQ_ALL_ONES)
               begin
                  view_in = view_ff - SEQ_ONE;
               end
            end
         end
         ST_WIPE: begin
            mem_we       = 1'b1;
            mem_waddr    = clr_ff;
            clr_in       = clr_ff + AW'(1);
            sel_valid_in = 1'b0;
            nw_valid_in  = 1'b0;
            wrap_in      = '0;
            view_in      = '0;
            cur_in       = '0;
         end
         ST_LOAD: begin
            if (func_ff == FUNC_LOAD_SLOT && idx_ok) begin
               mem_we      = 1'b1;
               mem_waddr   = AW'(idx_ff);
               mem_wdata   = val_ff;
               nw_valid_in = 1'b0;
               if (sel_valid_ff && 32'(sel_idx_ff) == 32'(idx_ff)) cur_in = val_ff;
            end
            if (func_ff == FUNC_LOAD_EPOCH) begin
               wrap_in = val_ff;
               view_in = val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sel_valid_ff <= 1'b0;
         nw_valid_ff  <= 1'b0;
         wrap_ff      <= '0;
         view_ff      <= '0;
         cur_ff       <= '0;
         moved_ff     <= 1'b0;
         bumped_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sel_valid_ff <= sel_valid_in;
         nw_valid_ff  <= nw_valid_in;
         wrap_ff      <= wrap_in;
         view_ff      <= view_in;
         cur_ff       <= cur_in;
         moved_ff     <= moved_in;
         bumped_ff    <= bumped_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      sel_idx_ff    <= sel_idx_in;
      nw_idx_ff     <= nw_idx_in;
      scan_i_ff     <= scan_i_in;
      chk_idx_ff    <= chk_idx_in;
      best_valid_ff <= best_valid_in;
      best_idx_ff   <= best_idx_in;
      best_seq_ff   <= best_seq_in;
      tgt_ff        <= tgt_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign done      = (state_ff == ST_RESP);

   always_comb begin
      result.current_slot = sel_valid_ff ? SLOT_W'(sel_idx_ff) : '1;
      result.current_seq  = cur_ff;
      result.log_number   = {view_ff, cur_ff};
      result.moved        = moved_ff;
      result.latest_slot  = nw_valid_ff ? SLOT_W'(nw_idx_ff) : '1;
      result.stored_epoch = wrap_ff;
      result.epoch_bumped = bumped_ff;
   end

   `CLST_ASSERT_NEXT(a_append_sets_newest, clock, reset, state_ff == ST_APPEND_WR, nw_valid_ff && sel_valid_ff && nw_idx_ff == sel_idx_ff)
   `CLST_ASSERT_IMPL(a_no_sel_zero_seq, clock, reset, !sel_valid_ff, cur_ff == '0)
   `CLST_ASSERT_IMPL(a_write_states, clock, reset, mem_we, state_ff == ST_APPEND_WR || state_ff == ST_LOAD || state_ff == ST_CLEAR || state_ff == ST_WIPE)
   `CLST_ASSERT_IMPL(a_scan_in_ring, clock, reset, chk_valid_ff, CW'(chk_idx_ff) < n_val)

endmodule

[design/circular_log_sequence_tracker.sv]
// ----------------------------------------------------------------------------
// circular_log_sequence_tracker
// Ring of log slots with wrap-aware sequence numbers, append, browse, find
// latest, wipe and preload.
//
//   port group  dir  transfer when         carries
//   csr_*       in   csr_valid & ready     slots_in_use
//   req_*       in   req_valid & ready     func, slot_index, seq_value
//   rsp_*       out  rsp_valid & ready     status of the selected slot, epochs
//
// One item at a time through the slot store's single read port; a result
// register holds the last status so the next item can be taken meanwhile.
// req_ready stays low while an item is busy. Append and find latest read the
// newest slot when it is known, else scan the ring in use one slot per cycle;
// browse reads at most slot 0 and the target slot; wipe clears every slot.
// A full, stalled result register holds the sequencer in its response state.
// After reset the store is cleared, one slot per cycle, before req_ready
// rises; csr writes are taken at any time.
// ----------------------------------------------------------------------------
module circular_log_sequence_tracker import clst_pkg::*; #(
   parameter int MAX_SLOTS = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_slots_in_use,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [IDX_W-1:0]         req_slot_index,
   input  logic [SEQ_W-1:0]         req_seq_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SLOT_W-1:0] rsp_current_slot,
   output logic [SEQ_W-1:0]         rsp_current_seq,
   output logic [2*SEQ_W-1:0]       rsp_log_number,
   output logic                     rsp_moved,
   output logic signed [SLOT_W-1:0] rsp_latest_slot,
   output logic [SEQ_W-1:0]         rsp_stored_epoch,
   output logic                     rsp_epoch_bumped
);

   logic [CSR_W-1:0] csr_ff, csr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_free;
   logic             seq_done;
   rsp_type          seq_result;

   clst_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .slots_in_use   (csr_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_slot_index (req_slot_index),
      .req_seq_value  (req_seq_value),
      .rsp_free       (rsp_free),
      .done           (seq_done),
      .result         (seq_result)
   );

   assign csr_ready = 1'b1;
   assign csr_in    = (csr_valid && csr_ready) ? csr_slots_in_use : csr_ff;

   // result register frees up in the same cycle it is taken
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (seq_done && rsp_free) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = (seq_done && rsp_free) ? seq_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_slot = $signed(rsp_data_ff.current_slot);
   assign rsp_current_seq  = rsp_data_ff.current_seq;
   assign rsp_log_number   = rsp_data_ff.log_number;
   assign rsp_moved        = rsp_data_ff.moved;
   assign rsp_latest_slot  = $signed(rsp_data_ff.latest_slot);
   assign rsp_stored_epoch = rsp_data_ff.stored_epoch;
   assign rsp_epoch_bumped = rsp_data_ff.epoch_bumped;

endmodule

[tb/circular_log_sequence_tracker_checker.sv]
// ----------------------------------------------------------------------------
// Circular log sequence tracker checker
// Watches the csr, req and rsp channels and keeps its own copy of the slot
// ring, selection and epochs. Each accepted request produces a predicted
// status, and each accepted status is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module circular_log_sequence_tracker_checker import clst_pkg::*; #(
   parameter int MAX_SLOTS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_slots_in_use,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [IDX_W-1:0]  req_slot_index,
   input  logic [SEQ_W-1:0]  req_seq_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [SLOT_W-1:0] rsp_current_slot,
   input  logic [SEQ_W-1:0]  rsp_current_seq,
   input  logic [2*SEQ_W-1:0] rsp_log_number,
   input  logic              rsp_moved,
   input  logic [SLOT_W-1:0] rsp_latest_slot,
   input  logic [SEQ_W-1:0]  rsp_stored_epoch,
   input  logic              rsp_epoch_bumped,
   output int                mismatches,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = $clog2(MAX_SLOTS);

   logic [SEQ_W-1:0] seq_store [MAX_SLOTS];
   int               pick;         // selected slot, -1 when none
   int               top_slot;     // newest slot, -1 when unknown
   logic [SEQ_W-1:0] epoch_count;
   logic [SEQ_W-1:0] view_epoch;
   logic [CSR_W-1:0] ring_cfg;
   rsp_type          status_due [$];
   int               errors;

   function automatic int ring_len();
      int n;
      n = int'(ring_cfg);
      if (n < 1) n = 1;
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n;
   endfunction

   // serial-number order: a is newer when a - b lands in the lower half
   function automatic bit seq_newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d != '0) && (d < 16'h8000);
   endfunction

   function automatic logic [SEQ_W-1:0] seq_of(int s);
      if (s < 0 || s >= MAX_SLOTS) return '0;
      return seq_store[AW'(s)];
   endfunction

   function automatic void seek_top();
      int               best;
      logic [SEQ_W-1:0] best_seq;
      logic [SEQ_W-1:0] s;
      if (top_slot >= 0) begin
         pick = top_slot;
      end else begin
         best = -1;
         best_seq = '0;
         for (int i = 0; i < ring_len(); i++) begin
            s = seq_store[AW'(i)];
            if (s != '0 && (best < 0 || seq_newer(s, best_seq))) begin
               best = i;
               best_seq = s;
            end
         end
         pick = best;
         top_slot = best;
      end
      view_epoch = epoch_count;
   endfunction

   function automatic int ring_next(int from, bit fwd);
      int n;
      n = ring_len();
      if (fwd) return (from + 1 >= n) ? 0 : from + 1;
      if (from <= 0 || from > n) return n - 1;
      return from - 1;
   endfunction

   function automatic bit walk(bit fwd);
      int               from;
      int               dest;
      logic [SEQ_W-1:0] a;
      logic [SEQ_W-1:0] b;
      if (fwd && pick < 0) begin
         pick = 0;
         return 1'b1;
      end
      from = (pick < 0) ? 0 : pick;
      pick = from;
      dest = ring_next(from, fwd);
      a = seq_of(from);
      b = seq_of(dest);
      if (b == '0) return 1'b0;
      if (fwd && seq_newer(b, a)) begin
         if (a == SEQ_ALL_ONES && b == SEQ_ONE) view_epoch = view_epoch + SEQ_ONE;
         pick = dest;
         return 1'b1;
      end
      if (!fwd && seq_newer(a, b)) begin
         if (a == SEQ_ONE && b == SEQ_ALL_ONES) view_epoch = view_epoch - SEQ_ONE;
         pick = dest;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type next_status(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                           logic [SEQ_W-1:0] val);
      rsp_type          r;
      logic [SEQ_W-1:0] nxt;
      logic [SEQ_W-1:0] cur;
      r = '0;
      case (f)
         FUNC_APPEND: begin
            seek_top();
            nxt = seq_of(pick) + SEQ_ONE;
            if (nxt == '0) begin
               nxt = SEQ_ONE;
               epoch_count = epoch_count + SEQ_ONE;
               view_epoch = epoch_count;
               r.epoch_bumped = 1'b1;
            end
            pick = (pick < 0) ? 0 : ring_next(pick, 1'b1);
            seq_store[AW'(pick)] = nxt;
            top_slot = pick;
         end
         FUNC_BR_NEXT: r.moved = walk(1'b1);
         FUNC_BR_PREV: r.moved = walk(1'b0);
         FUNC_FIND:    seek_top();
         FUNC_WIPE: begin
            foreach (seq_store[i]) seq_store[i] = '0;
            epoch_count = '0;
            view_epoch = '0;
            pick = -1;
            top_slot = -1;
         end
         FUNC_LOAD_SLOT: begin
            if (int'(idx) < MAX_SLOTS) begin
               seq_store[AW'(idx)] = val;
               top_slot = -1;
            end
         end
         FUNC_LOAD_EPOCH: begin
            epoch_count = val;
            view_epoch = val;
         end
         default: ;
      endcase
      cur = seq_of(pick);
      r.current_slot = pick[SLOT_W-1:0];
      r.current_seq = cur;
      r.log_number = {view_epoch, cur};
      r.latest_slot = top_slot[SLOT_W-1:0];
      r.stored_epoch = epoch_count;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (seq_store[i]) seq_store[i] = '0;
         pick = -1;
         top_slot = -1;
         epoch_count = '0;
         view_epoch = '0;
         ring_cfg = CSR_RESET;
         status_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) ring_cfg = csr_slots_in_use;
         // compare before queueing: a status never leaves on its own request's edge
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $error("status transfer with no request outstanding");
               errors++;
            end else begin
               want = status_due.pop_front();
               check_field("current_slot", 32'(want.current_slot), 32'(rsp_current_slot));
               check_field("current_seq", 32'(want.current_seq), 32'(rsp_current_seq));
               check_field("log_number", want.log_number, rsp_log_number);
               check_field("moved", 32'(want.moved), 32'(rsp_moved));
               check_field("latest_slot", 32'(want.latest_slot), 32'(rsp_latest_slot));
               check_field("stored_epoch", 32'(want.stored_epoch), 32'(rsp_stored_epoch));
               check_field("epoch_bumped", 32'(want.epoch_bumped), 32'(rsp_epoch_bumped));
            end
         end
         if (req_valid && req_ready)
            status_due.push_back(next_status(req_func, req_slot_index, req_seq_value));
      end
      mismatches <= errors;
      outstanding <= status_due.size();
   end

endmodule

[tb/circular_log_sequence_tracker_tb.sv]
// ----------------------------------------------------------------------------
// Circular log sequence tracker testbench
// Directed requests cover empty-log browsing, sequence wrap with epoch bump,
// epoch rollover, serial-number ordering and a selection left beyond a lowered
// ring size. Random phases then run append/browse-heavy traffic under several
// ring sizes with random sender gaps and status stalls.
// ----------------------------------------------------------------------------
module circular_log_sequence_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clst_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 300;
   localparam int PHASES      = 8;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_W-1:0]         csr_slots_in_use = CSR_RESET;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [IDX_W-1:0]         req_slot_index = '0;
   logic [SEQ_W-1:0]         req_seq_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [SLOT_W-1:0] rsp_current_slot;
   logic [SEQ_W-1:0]         rsp_current_seq;
   logic [2*SEQ_W-1:0]       rsp_log_number;
   logic                     rsp_moved;
   logic signed [SLOT_W-1:0] rsp_latest_slot;
   logic [SEQ_W-1:0]         rsp_stored_epoch;
   logic                     rsp_epoch_bumped;

   int mismatches;
   int outstanding;
   int ring_size = 128;
   int stall_pct = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   int ring_plan  [PHASES] = '{4, 1, 128, 2, 127, 64, 33, 128};
   int idle_plan  [PHASES] = '{30, 20, 0, 50, 30, 0, 40, 0};
   int stall_plan [PHASES] = '{30, 0, 40, 50, 30, 0, 20, 0};

   circular_log_sequence_tracker uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_seq_value    (req_seq_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_current_slot (rsp_current_slot),
      .rsp_current_seq  (rsp_current_seq),
      .rsp_log_number   (rsp_log_number),
      .rsp_moved        (rsp_moved),
      .rsp_latest_slot  (rsp_latest_slot),
      .rsp_stored_epoch (rsp_stored_epoch),
      .rsp_epoch_bumped (rsp_epoch_bumped)
   );

   circular_log_sequence_tracker_checker status_check (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_seq_value    (req_seq_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_current_slot (rsp_current_slot),
      .rsp_current_seq  (rsp_current_seq),
      .rsp_log_number   (rsp_log_number),
      .rsp_moved        (rsp_moved),
      .rsp_latest_slot  (rsp_latest_slot),
      .rsp_stored_epoch (rsp_stored_epoch),
      .rsp_epoch_bumped (rsp_epoch_bumped),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always #2 clock = ~clock;

   // status side: ready drops in bursts that start with a chance of stall_pct percent
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(8, 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("** circular_log_sequence_tracker: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                            logic [SEQ_W-1:0] val);
      req_valid <= 1'b1;
      req_func <= f;
      req_slot_index <= idx;
      req_seq_value <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off requests until every status has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_ring(logic [CSR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_slots_in_use <= v;
      ring_size = int'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count, int idle_pct);
      logic [FUNC_W-1:0] f;
      logic [IDX_W-1:0]  idx;
      logic [SEQ_W-1:0]  val;
      int                roll;
      for (int k = 0; k < count; k++) begin
         if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clock);
         end else if (idle_pct != 0 && $urandom_range(39, 0) == 0) begin
            drain();
         end
         // mostly appends and browses so the ring fills and wraps
         roll = $urandom_range(99, 0);
         if (roll < 30)      f = FUNC_APPEND;
         else if (roll < 48) f = FUNC_BR_NEXT;
         else if (roll < 66) f = FUNC_BR_PREV;
         else if (roll < 73) f = FUNC_FIND;
         else if (roll < 85) f = FUNC_LOAD_SLOT;
         else if (roll < 91) f = FUNC_LOAD_EPOCH;
         else if (roll < 93) f = FUNC_WIPE;
         else                f = FUNC_UNUSED;
         if ($urandom_range(3, 0) != 0) idx = IDX_W'($urandom_range(ring_size - 1, 0));
         else                          idx = IDX_W'($urandom);
         // near-wrap values let a short run of appends cross 0xFFFF
         roll = $urandom_range(9, 0);
         if (roll < 4)      val = SEQ_W'($urandom_range(65535, 65520));
         else if (roll < 6) val = SEQ_W'($urandom_range(16, 0));
         else if (roll < 7) val = '0;
         else               val = SEQ_W'($urandom);
         send_item(f, idx, val);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      stall_pct <= 25;
      write_ring(CSR_RESET);

      send_item(FUNC_FIND, '0, '0);
      send_item(FUNC_BR_PREV, '0, '0);
      send_item(FUNC_WIPE, '0, '0);
      send_item(FUNC_BR_NEXT, '0, '0);
      send_item(FUNC_APPEND, '0, '0);
      send_item(FUNC_WIPE, '0, '0);
      send_item(FUNC_LOAD_SLOT, 7'd126, 16'hFFFE);
      send_item(FUNC_LOAD_SLOT, 7'd127, SEQ_ALL_ONES);
      send_item(FUNC_FIND, '0, '0);
      send_item(FUNC_APPEND, '0, '0);
      // walk back across the wrap and forward again
      send_item(FUNC_BR_PREV, '0, '0);
      send_item(FUNC_BR_PREV, '0, '0);
      send_item(FUNC_BR_NEXT, '0, '0);
      send_item(FUNC_BR_NEXT, '0, '0);
      send_item(FUNC_BR_NEXT, '0, '0);
      // epoch rolls over from all ones
      send_item(FUNC_WIPE, '0, '0);
      send_item(FUNC_LOAD_EPOCH, '0, SEQ_ALL_ONES);
      send_item(FUNC_LOAD_SLOT, 7'd5, SEQ_ALL_ONES);
      send_item(FUNC_APPEND, '0, '0);
      send_item(FUNC_UNUSED, 7'd127, SEQ_ALL_ONES);
      send_item(FUNC_LOAD_SLOT, 7'd5, '0);
      send_item(FUNC_LOAD_SLOT, 7'd100, 16'h8000);
      send_item(FUNC_FIND, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_ring(CSR_W'(ring_plan[p]));
         stall_pct <= stall_plan[p];
         if (p == 0) begin
            // selection still at slot 100, beyond the shrunken ring
            send_item(FUNC_LOAD_SLOT, 7'd0, 16'h8001);
            send_item(FUNC_BR_NEXT, '0, '0);
         end
         run_random(125, idle_plan[p]);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("** circular_log_sequence_tracker: PASSED **");
      else
         $display("** circular_log_sequence_tracker: FAILED **");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/clst_pkg.sv
design/clst_mem.sv
design/clst_newer.sv
design/clst_seq.sv
design/circular_log_sequence_tracker.sv
tb/circular_log_sequence_tracker_checker.sv
tb/circular_log_sequence_tracker_tb.sv
